// File: design/i2cms_pkg.sv
// Shared types and constants for the I2C master bit sequencer.
`timescale 1ns / 1ps

package i2cms_pkg;

   localparam logic [2:0] CMD_NONE    = 3'd0;
   localparam logic [2:0] CMD_START   = 3'd1;
   localparam logic [2:0] CMD_STOP    = 3'd2;
   localparam logic [2:0] CMD_WRITE   = 3'd3;
   localparam logic [2:0] CMD_READ    = 3'd4;
   localparam logic [2:0] CMD_ACK     = 3'd5;
   localparam logic [2:0] CMD_NACK    = 3'd6;
   localparam logic [2:0] CMD_WAITACK = 3'd7;

   localparam logic [1:0] CSR_BIT_PHASE_TICKS = 2'd0;
   localparam logic [1:0] CSR_ACK_PHASE_TICKS = 2'd1;
   localparam logic [1:0] CSR_ACK_POLL_LIMIT  = 2'd2;

   localparam logic [7:0] BIT_PHASE_TICKS_RESET = 8'd4;
   localparam logic [7:0] ACK_PHASE_TICKS_RESET = 8'd2;
   localparam logic [7:0] ACK_POLL_LIMIT_RESET  = 8'd250;

   typedef struct packed {
      logic [7:0] bit_phase_ticks;
      logic [7:0] ack_phase_ticks;
      logic [7:0] ack_poll_limit;
   } cfg_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] tx_byte;
      logic       sda_sample;
   } item_type;

   typedef struct packed {
      logic [2:0] active_command;
      logic [2:0] phase_step;
      logic [7:0] delay_count;
      logic [2:0] bit_index;
      logic [7:0] shift_byte;
      logic [7:0] poll_count;
      logic       scl_drive;
      logic       sda_drive;
      logic [7:0] received_byte;
      logic       fail_flag;
      logic       done_pulse;
   } seq_state_type;

   localparam seq_state_type SEQ_STATE_RESET = '{
      active_command: CMD_NONE,
      phase_step:     3'd0,
      delay_count:    8'd0,
      bit_index:      3'd0,
      shift_byte:     8'd0,
      poll_count:     8'd0,
      scl_drive:      1'b1,
      sda_drive:      1'b1,
      received_byte:  8'd0,
      fail_flag:      1'b0,
      done_pulse:     1'b0
   };

endpackage

// File: design/i2cms_csr.sv
// Configuration registers for phase timing and the ack poll limit.
`timescale 1ns / 1ps

module i2cms_csr import i2cms_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  logic [1:0] wr_index,
   input  logic [7:0] wr_data,
   output cfg_type    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_BIT_PHASE_TICKS: cfg_in.bit_phase_ticks = wr_data;
            CSR_ACK_PHASE_TICKS: cfg_in.ack_phase_ticks = wr_data;
            CSR_ACK_POLL_LIMIT:  cfg_in.ack_poll_limit  = wr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_phase_ticks <= BIT_PHASE_TICKS_RESET;
         cfg_ff.ack_phase_ticks <= ACK_PHASE_TICKS_RESET;
         cfg_ff.ack_poll_limit  <= ACK_POLL_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/i2cms_step.sv
// Next-state logic of the line sequencer for one timing tick.
`timescale 1ns / 1ps

module i2cms_step import i2cms_pkg::*; (
   input  seq_state_type cur,
   input  item_type      item,
   input  cfg_type       cfg,
   output seq_state_type nxt
);

   // A phase lasts the programmed count; zero is treated as one tick.
   function automatic logic [7:0] load_delay(input logic [7:0] ticks);
      return (ticks != 8'd0) ? ticks - 8'd1 : 8'd0;
   endfunction

   function automatic seq_state_type finish(input seq_state_type s);
      seq_state_type r;
      r = s;
      r.active_command = CMD_NONE;
      r.phase_step     = 3'd0;
      r.delay_count    = 8'd0;
      r.bit_index      = 3'd0;
      r.poll_count     = 8'd0;
      r.done_pulse     = 1'b1;
      return r;
   endfunction

   // Stop phases that follow an ack timeout (phase steps three to five).
   function automatic seq_state_type enter_timeout_stop(input seq_state_type s,
                                                        input logic [2:0] p,
                                                        input cfg_type c);
      seq_state_type r;
      r = s;
      r.phase_step = p;
      if (p == 3'd3) begin
         r.sda_drive = 1'b0;
         r.scl_drive = 1'b0;
      end else if (p == 3'd4) begin
         r.scl_drive = 1'b1;
      end else begin
         r.sda_drive = 1'b1;
      end
      r.delay_count = load_delay(c.bit_phase_ticks);
      return r;
   endfunction

   function automatic seq_state_type poll_ack(input seq_state_type s, input logic sda,
                                              input cfg_type c);
      seq_state_type r;
      r = s;
      if (!sda) begin
         r.scl_drive = 1'b0;
         r.fail_flag = 1'b0;
         r = finish(r);
      end else if (r.poll_count >= c.ack_poll_limit) begin
         r = enter_timeout_stop(r, 3'd3, c);
      end else begin
         r.poll_count = r.poll_count + 8'd1;
      end
      return r;
   endfunction

   function automatic seq_state_type enter_phase(input seq_state_type s,
                                                 input logic [2:0] p,
                                                 input logic sda,
                                                 input cfg_type c);
      seq_state_type r;
      r = s;
      r.phase_step = p;
      case (r.active_command)
         CMD_START: begin
            if (p == 3'd0) begin
               r.sda_drive = 1'b1;
               r.scl_drive = 1'b1;
            end else if (p == 3'd1) begin
               r.sda_drive = 1'b0;
            end else begin
               r.scl_drive = 1'b0;
            end
            r.delay_count = load_delay(c.bit_phase_ticks);
         end
         CMD_STOP: begin
            if (p == 3'd0) begin
               r.sda_drive = 1'b0;
               r.scl_drive = 1'b0;
            end else if (p == 3'd1) begin
               r.scl_drive = 1'b1;
            end else begin
               r.sda_drive = 1'b1;
            end
            r.delay_count = load_delay(c.bit_phase_ticks);
         end
         CMD_WRITE: begin
            if (p == 3'd0) begin
               r.sda_drive = r.shift_byte[3'd7 - r.bit_index];
            end else if (p == 3'd1) begin
               r.scl_drive = 1'b1;
            end else begin
               r.scl_drive = 1'b0;
            end
            r.delay_count = load_delay(c.bit_phase_ticks);
         end
         CMD_READ: begin
            if (p == 3'd0) begin
               r.sda_drive = 1'b1;
            end else if (p == 3'd1) begin
               r.scl_drive = 1'b1;
            end else if (p == 3'd2) begin
               r.shift_byte = {r.shift_byte[6:0], sda};
            end else begin
               r.scl_drive = 1'b0;
            end
            r.delay_count = load_delay(c.bit_phase_ticks);
         end
         CMD_ACK, CMD_NACK: begin
            if (p == 3'd0) begin
               r.sda_drive = (r.active_command == CMD_NACK);
            end else if (p == 3'd1) begin
               r.scl_drive = 1'b1;
            end else begin
               r.scl_drive = 1'b0;
            end
            r.delay_count = load_delay(c.ack_phase_ticks);
         end
         CMD_WAITACK: begin
            if (p == 3'd0) begin
               r.sda_drive   = 1'b1;
               r.delay_count = load_delay(c.ack_phase_ticks);
            end else if (p == 3'd1) begin
               r.scl_drive   = 1'b1;
               r.delay_count = load_delay(c.ack_phase_ticks);
            end else if (p == 3'd2) begin
               r.delay_count = 8'd0;
               r = poll_ack(r, sda, c);
            end else begin
               r = enter_timeout_stop(r, p, c);
            end
         end
         default: r = s;
      endcase
      return r;
   endfunction

   function automatic seq_state_type advance(input seq_state_type s, input logic sda,
                                             input cfg_type c);
      seq_state_type r;
      logic [2:0]    p;
      r = s;
      p = s.phase_step;
      case (s.active_command)
         CMD_START, CMD_STOP, CMD_ACK, CMD_NACK: begin
            if (p < 3'd2) r = enter_phase(r, p + 3'd1, sda, c);
            else          r = finish(r);
         end
         CMD_WRITE: begin
            if (p < 3'd2) begin
               r = enter_phase(r, p + 3'd1, sda, c);
            end else if (r.bit_index < 3'd7) begin
               r.bit_index = r.bit_index + 3'd1;
               r = enter_phase(r, 3'd0, sda, c);
            end else begin
               r = finish(r);
            end
         end
         CMD_READ: begin
            if (p < 3'd3) begin
               r = enter_phase(r, p + 3'd1, sda, c);
            end else if (r.bit_index < 3'd7) begin
               r.bit_index = r.bit_index + 3'd1;
               r = enter_phase(r, 3'd1, sda, c);
            end else begin
               r.received_byte = r.shift_byte;
               r = finish(r);
            end
         end
         CMD_WAITACK: begin
            if (p inside {[3'd0:3'd1], [3'd3:3'd4]}) begin
               r = enter_phase(r, p + 3'd1, sda, c);
            end else begin
               r.fail_flag = 1'b1;
               r = finish(r);
            end
         end
         default: r = finish(r);
      endcase
      return r;
   endfunction

   always_comb begin
      nxt = cur;
      nxt.done_pulse = 1'b0;
      if (cur.active_command == CMD_NONE) begin
         if (item.cmd != CMD_NONE) begin
            nxt.active_command = item.cmd;
            nxt.bit_index      = 3'd0;
            nxt.poll_count     = 8'd0;
            nxt.shift_byte     = (item.cmd == CMD_WRITE) ? item.tx_byte : 8'd0;
            nxt = enter_phase(nxt, 3'd0, item.sda_sample, cfg);
         end
      end else if (cur.active_command == CMD_WAITACK && cur.phase_step == 3'd2) begin
         nxt = poll_ack(nxt, item.sda_sample, cfg);
      end else if (cur.delay_count != 8'd0) begin
         nxt.delay_count = cur.delay_count - 8'd1;
      end else begin
         nxt = advance(nxt, item.sda_sample, cfg);
      end
   end

endmodule

// File: design/i2c_master_bit_sequencer.sv
// Top level of the I2C master bit sequencer: tick pipeline, state and result register.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake            Word
//  req_      in         valid / stall        cmd, tx_byte, sda_sample (one tick)
//  rsp_      out        valid / stall        scl, sda, busy, done, rx_byte, ack_failed
//  csr_      in         valid / ready        register index, 8-bit data
//
// Every accepted word is one timing tick and yields exactly one result word.
// A word is held in the input register; the sequencer state steps and the result
// register loads from it once the result register has room, and one word is taken
// every cycle while the result side does not stall. Reset releases SCL and SDA and
// restores register defaults. A stall on the result side holds the result register;
// the input side then stalls once its register is full.

module i2c_master_bit_sequencer import i2cms_pkg::*; (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_cmd,
   input  logic [7:0] req_tx_byte,
   input  logic       req_sda_sample,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_scl_level,
   output logic       rsp_sda_level,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic [7:0] rsp_rx_byte,
   output logic       rsp_ack_failed,

   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   cfg_type       cfg;
   seq_state_type state_ff;
   seq_state_type state_in;

   logic     in_valid_ff;
   logic     in_valid_in;
   item_type in_item_ff;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   logic     req_accept;
   logic     step_en;

   logic       rsp_scl_ff;
   logic       rsp_sda_ff;
   logic       rsp_busy_ff;
   logic       rsp_done_ff;
   logic [7:0] rsp_rx_ff;
   logic       rsp_fail_ff;

   // Registers accept a write in any cycle; software must write only while idle.
   assign csr_ready = 1'b1;

   i2cms_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   i2cms_step u_step (
      .cur  (state_ff),
      .item (in_item_ff),
      .cfg  (cfg),
      .nxt  (state_in)
   );

   // The held tick steps the sequencer whenever the result register has room.
   assign step_en    = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !step_en;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept)   in_valid_in = 1'b1;
      else if (step_en) in_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (step_en) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= SEQ_STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step_en) state_ff <= state_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.cmd        <= req_cmd;
         in_item_ff.tx_byte    <= req_tx_byte;
         in_item_ff.sda_sample <= req_sda_sample;
      end
      if (step_en) begin
         rsp_scl_ff  <= state_in.scl_drive;
         rsp_sda_ff  <= state_in.sda_drive;
         rsp_busy_ff <= (state_in.active_command != CMD_NONE);
         rsp_done_ff <= state_in.done_pulse;
         rsp_rx_ff   <= state_in.received_byte;
         rsp_fail_ff <= state_in.fail_flag;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scl_level  = rsp_scl_ff;
   assign rsp_sda_level  = rsp_sda_ff;
   assign rsp_busy_res   = rsp_busy_ff;
   assign rsp_done_res   = rsp_done_ff;
   assign rsp_rx_byte    = rsp_rx_ff;
   assign rsp_ack_failed = rsp_fail_ff;

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the I2C master bit sequencer.
`timescale 1ns / 1ps

// Every accepted input word is one timing tick. The testbench keeps its own copy of the
// sequencer state and the three timing registers. It works out the expected result word
// for each tick at the moment the block accepts that tick. A checker process compares
// each result word the block hands out with the oldest prediction.
//
// Stimulus is organized as whole commands. A command word is followed by filler ticks
// until the predicted sequencer is idle again. The SDA level of each filler tick is
// chosen from the predicted state, so that reads assemble a chosen byte and wait-ack
// sees the ack after a chosen number of polls, or never. Filler ticks may carry stray
// commands, which the block must ignore while busy.

module tb_top import i2cms_pkg::*; ();

   localparam int CYCLE_LIMIT = 500000;
   // Ack delay that no poll limit can reach, so the wait-ack always times out.
   localparam int ACK_NEVER = 1000;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy;
      logic       done;
      logic [7:0] rx;
      logic       failed;
   } bus_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_cmd = CMD_NONE;
   logic [7:0] req_tx_byte = 8'd0;
   logic       req_sda_sample = 1'b1;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_scl_level;
   logic       rsp_sda_level;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   logic [7:0] rsp_rx_byte;
   logic       rsp_ack_failed;

   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = CSR_BIT_PHASE_TICKS;
   logic [7:0] csr_data = 8'd0;

   // Predicted timing registers.
   logic [7:0] cfg_bit_ticks;
   logic [7:0] cfg_ack_ticks;
   logic [7:0] cfg_poll_limit;

   // Predicted sequencer state and line drives.
   logic [2:0] seq_cmd;
   logic [2:0] seq_step;
   logic [7:0] seq_wait;
   logic [2:0] seq_bit;
   logic [7:0] seq_shift;
   logic [7:0] seq_polls;
   logic       line_scl;
   logic       line_sda;
   logic [7:0] seq_rx;
   logic       seq_fail;
   logic       seq_done;

   bus_result_type expected_bus[$];
   int             mismatch_count = 0;
   int             ticks_sent = 0;
   int             cycle_count = 0;

   // Idle control. gap_mode lets the sender insert gaps, stall_mode lets the receiver
   // stall at random, and hold_left forces a long receiver hold-off in cycles.
   bit          gap_mode = 1'b0;
   bit          stall_mode = 1'b0;
   int          hold_left = 0;
   int          stall_run = 0;

   i2c_master_bit_sequencer i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_tx_byte    (req_tx_byte),
      .req_sda_sample (req_sda_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_scl_level  (rsp_scl_level),
      .rsp_sda_level  (rsp_sda_level),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_rx_byte    (rsp_rx_byte),
      .rsp_ack_failed (rsp_ack_failed),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------
   // Sequencer prediction
   // ---------------------------------------------------------------------------------

   function automatic void predictor_reset();
      cfg_bit_ticks  = BIT_PHASE_TICKS_RESET;
      cfg_ack_ticks  = ACK_PHASE_TICKS_RESET;
      cfg_poll_limit = ACK_POLL_LIMIT_RESET;
      seq_cmd   = CMD_NONE;
      seq_step  = 3'd0;
      seq_wait  = 8'd0;
      seq_bit   = 3'd0;
      seq_shift = 8'd0;
      seq_polls = 8'd0;
      line_scl  = 1'b1;
      line_sda  = 1'b1;
      seq_rx    = 8'd0;
      seq_fail  = 1'b0;
      seq_done  = 1'b0;
   endfunction

   // A phase of N ticks holds for N-1 further ticks after its entry; zero acts as one.
   function automatic logic [7:0] phase_load(input logic [7:0] ticks);
      return (ticks != 8'd0) ? ticks - 8'd1 : 8'd0;
   endfunction

   function automatic void seq_finish();
      seq_cmd   = CMD_NONE;
      seq_step  = 3'd0;
      seq_wait  = 8'd0;
      seq_bit   = 3'd0;
      seq_polls = 8'd0;
      seq_done  = 1'b1;
   endfunction

   // Stop sequence phase k: both low, then SCL released, then SDA released.
   function automatic void drive_stop(input int k);
      if (k == 0) begin
         line_sda = 1'b0;
         line_scl = 1'b0;
      end else if (k == 1) begin
         line_scl = 1'b1;
      end else begin
         line_sda = 1'b1;
      end
      seq_wait = phase_load(cfg_bit_ticks);
   endfunction

   // One ack poll. A low SDA ends the command at once; too many high polls start the stop.
   function automatic void poll_ack(input logic sda);
      if (!sda) begin
         line_scl = 1'b0;
         seq_fail = 1'b0;
         seq_finish();
      end else if (seq_polls >= cfg_poll_limit) begin
         seq_step = 3'd3;
         drive_stop(0);
      end else begin
         seq_polls = seq_polls + 8'd1;
      end
   endfunction

   function automatic void enter_phase(input int p, input logic sda);
      seq_step = 3'(p);
      case (seq_cmd)
         CMD_START: begin
            if (p == 0) begin
               line_sda = 1'b1;
               line_scl = 1'b1;
            end else if (p == 1) begin
               line_sda = 1'b0;
            end else begin
               line_scl = 1'b0;
            end
            seq_wait = phase_load(cfg_bit_ticks);
         end
         CMD_STOP: begin
            drive_stop(p);
         end
         CMD_WRITE: begin
            if (p == 0) line_sda = seq_shift[3'd7 - seq_bit];
            else if (p == 1) line_scl = 1'b1;
            else line_scl = 1'b0;
            seq_wait = phase_load(cfg_bit_ticks);
         end
         CMD_READ: begin
            if (p == 0) line_sda = 1'b1;
            else if (p == 1) line_scl = 1'b1;
            else if (p == 2) seq_shift = {seq_shift[6:0], sda};
            else line_scl = 1'b0;
            seq_wait = phase_load(cfg_bit_ticks);
         end
         CMD_ACK, CMD_NACK: begin
            if (p == 0) line_sda = (seq_cmd == CMD_NACK);
            else if (p == 1) line_scl = 1'b1;
            else line_scl = 1'b0;
            seq_wait = phase_load(cfg_ack_ticks);
         end
         CMD_WAITACK: begin
            if (p == 0) begin
               line_sda = 1'b1;
               seq_wait = phase_load(cfg_ack_ticks);
            end else if (p == 1) begin
               line_scl = 1'b1;
               seq_wait = phase_load(cfg_ack_ticks);
            end else if (p == 2) begin
               // The first poll falls on the very tick the polling phase is entered.
               seq_wait = 8'd0;
               poll_ack(sda);
            end else begin
               drive_stop(p - 3);
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void advance(input logic sda);
      int p;
      p = int'(seq_step);
      case (seq_cmd)
         CMD_START, CMD_STOP, CMD_ACK, CMD_NACK: begin
            if (p < 2) enter_phase(p + 1, sda);
            else seq_finish();
         end
         CMD_WRITE: begin
            if (p < 2) begin
               enter_phase(p + 1, sda);
            end else if (seq_bit < 3'd7) begin
               seq_bit = seq_bit + 3'd1;
               enter_phase(0, sda);
            end else begin
               seq_finish();
            end
         end
         CMD_READ: begin
            // SDA stays released after the first phase, so later bits restart at SCL high.
            if (p < 3) begin
               enter_phase(p + 1, sda);
            end else if (seq_bit < 3'd7) begin
               seq_bit = seq_bit + 3'd1;
               enter_phase(1, sda);
            end else begin
               seq_rx = seq_shift;
               seq_finish();
            end
         end
         CMD_WAITACK: begin
            if (p < 2 || (p >= 3 && p < 5)) begin
               enter_phase(p + 1, sda);
            end else begin
               // End of the stop that follows an ack timeout.
               seq_fail = 1'b1;
               seq_finish();
            end
         end
         default: begin
            seq_finish();
         end
      endcase
   endfunction

   // Steps the predicted sequencer by one tick and returns the result word it yields.
   function automatic bus_result_type sequencer_tick(input logic [2:0] cmd,
                                                     input logic [7:0] tx,
                                                     input logic sda);
      seq_done = 1'b0;
      if (seq_cmd == CMD_NONE) begin
         if (cmd != CMD_NONE) begin
            seq_cmd   = cmd;
            seq_bit   = 3'd0;
            seq_polls = 8'd0;
            seq_shift = (cmd == CMD_WRITE) ? tx : 8'd0;
            enter_phase(0, sda);
         end
      end else if (seq_cmd == CMD_WAITACK && seq_step == 3'd2) begin
         poll_ack(sda);
      end else if (seq_wait != 8'd0) begin
         seq_wait = seq_wait - 8'd1;
      end else begin
         advance(sda);
      end
      return '{line_scl, line_sda, seq_cmd != CMD_NONE, seq_done, seq_rx, seq_fail};
   endfunction

   // ---------------------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------------------

   // Most gaps are short, a few are long, and with gap_mode clear the sender never idles.
   function automatic int pick_gap();
      int r;
      if (!gap_mode) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   // Sends one tick word and records its prediction once the block takes it.
   task automatic send_tick(input logic [2:0] cmd, input logic [7:0] tx, input logic sda);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_cmd        = cmd;
      req_tx_byte    = tx;
      req_sda_sample = sda;
      do @(posedge clock); while (req_stall);
      expected_bus.push_back(sequencer_tick(cmd, tx, sda));
      ticks_sent++;
   endtask

   // SDA for the next tick: a read sees the chosen byte bit by bit, a wait-ack sees SDA
   // low once the poll count reaches ack_after, and anything else sees noise.
   function automatic logic tick_sda(input logic [7:0] rd_pattern, input int ack_after);
      if (seq_cmd == CMD_READ) return rd_pattern[3'd7 - seq_bit];
      if (seq_cmd == CMD_WAITACK) return (int'(seq_polls) >= ack_after) ? 1'b0 : 1'b1;
      return 1'($urandom_range(1));
   endfunction

   function automatic logic [2:0] filler_cmd(input bit noise);
      if (noise && $urandom_range(3) == 0) return 3'($urandom_range(7));
      return CMD_NONE;
   endfunction

   // Issues one command and keeps ticking until the sequencer is idle again.
   task automatic run_command(input logic [2:0] cmd, input logic [7:0] tx,
                              input logic [7:0] rd_pattern, input int ack_after,
                              input bit noise);
      send_tick(cmd, tx, tick_sda(rd_pattern, ack_after));
      while (seq_cmd != CMD_NONE) begin
         send_tick(filler_cmd(noise), 8'($urandom), tick_sda(rd_pattern, ack_after));
      end
   endtask

   // Lets every outstanding result word drain, plus a margin for the pipeline.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_bus.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [7:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_BIT_PHASE_TICKS: cfg_bit_ticks  = value;
         CSR_ACK_PHASE_TICKS: cfg_ack_ticks  = value;
         CSR_ACK_POLL_LIMIT:  cfg_poll_limit = value;
         default: begin
         end
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_config(input logic [7:0] bit_ticks, input logic [7:0] ack_ticks,
                             input logic [7:0] poll_limit);
      drain();
      write_register(CSR_BIT_PHASE_TICKS, bit_ticks);
      write_register(CSR_ACK_PHASE_TICKS, ack_ticks);
      write_register(CSR_ACK_POLL_LIMIT, poll_limit);
   endtask

   function automatic int pick_ack_after();
      if ($urandom_range(7) == 0) return ACK_NEVER;
      return $urandom_range(int'(cfg_poll_limit));
   endfunction

   // One bus transaction: start, address, ack, a few data bytes in the address's
   // direction, stop. A timed-out ack ends it early, since the block then stops by itself.
   task automatic run_transaction();
      logic [7:0] addr;
      int         n_bytes;
      bit         noise;
      addr    = 8'($urandom);
      n_bytes = $urandom_range(3, 1);
      noise   = ($urandom_range(3) == 0);
      run_command(CMD_START, 8'($urandom), 8'($urandom), 0, noise);
      run_command(CMD_WRITE, addr, 8'($urandom), 0, noise);
      run_command(CMD_WAITACK, 8'($urandom), 8'($urandom), pick_ack_after(), noise);
      if (seq_fail) return;
      for (int i = 0; i < n_bytes; i++) begin
         if (addr[0]) begin
            run_command(CMD_READ, 8'($urandom), 8'($urandom), 0, noise);
            run_command((i == n_bytes - 1) ? CMD_NACK : CMD_ACK, 8'($urandom),
                        8'($urandom), 0, noise);
         end else begin
            run_command(CMD_WRITE, 8'($urandom), 8'($urandom), 0, noise);
            run_command(CMD_WAITACK, 8'($urandom), 8'($urandom), pick_ack_after(), noise);
            if (seq_fail) return;
         end
      end
      run_command(CMD_STOP, 8'($urandom), 8'($urandom), 0, noise);
   endtask

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // The register defaults after reset must give the documented phase lengths.
   task automatic test_reset_defaults();
      gap_mode   = 1'b1;
      stall_mode = 1'b1;
      run_command(CMD_START, 8'h00, 8'h00, 0, 1'b0);
      run_command(CMD_WRITE, 8'h3C, 8'h00, 0, 1'b0);
      run_command(CMD_WAITACK, 8'h00, 8'h00, 5, 1'b0);
      run_command(CMD_STOP, 8'h00, 8'h00, 0, 1'b0);
   endtask

   // Every command at least once with the shortest phases: byte extremes, read patterns,
   // an ack right at the first poll and one right at the poll limit, a timeout followed
   // by a good ack that clears the failure flag, and stray commands while busy.
   task automatic test_directed_commands();
      gap_mode   = 1'b0;
      stall_mode = 1'b0;
      set_config(8'd1, 8'd1, 8'd3);
      run_command(CMD_NONE, 8'hFF, 8'h00, 0, 1'b0);
      run_command(CMD_START, 8'h00, 8'h00, 0, 1'b0);
      run_command(CMD_WRITE, 8'hFF, 8'h00, 0, 1'b0);
      run_command(CMD_WAITACK, 8'h00, 8'h00, 0, 1'b0);
      run_command(CMD_WRITE, 8'h00, 8'h00, 0, 1'b0);
      run_command(CMD_WAITACK, 8'h00, 8'h00, 3, 1'b0);
      gap_mode   = 1'b1;
      stall_mode = 1'b1;
      run_command(CMD_READ, 8'h00, 8'hFF, 0, 1'b0);
      run_command(CMD_ACK, 8'h00, 8'h00, 0, 1'b0);
      run_command(CMD_READ, 8'hFF, 8'h00, 0, 1'b0);
      run_command(CMD_NACK, 8'h00, 8'h00, 0, 1'b0);
      run_command(CMD_READ, 8'h00, 8'hA5, 0, 1'b1);
      run_command(CMD_WAITACK, 8'h00, 8'h00, ACK_NEVER, 1'b1);
      run_command(CMD_WAITACK, 8'h00, 8'h00, 1, 1'b1);
      run_command(CMD_STOP, 8'h00, 8'h00, 0, 1'b1);
   endtask

   // The highest poll limit, run out by a wait-ack that never sees the ack.
   task automatic test_long_poll();
      gap_mode   = 1'b0;
      stall_mode = 1'b1;
      set_config(8'd1, 8'd1, 8'd255);
      run_command(CMD_WAITACK, 8'h00, 8'h00, ACK_NEVER, 1'b1);
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering ticks,
   // so the block fills up and must stall its input side without losing a word.
   task automatic test_back_pressure();
      set_config(8'd2, 8'd2, 8'd4);
      gap_mode   = 1'b0;
      stall_mode = 1'b0;
      hold_left  = 60;
      run_command(CMD_WRITE, 8'($urandom), 8'h00, 0, 1'b1);
      stall_mode = 1'b1;
      hold_left  = 40;
      run_command(CMD_READ, 8'h00, 8'($urandom), 0, 1'b1);
   endtask

   // Mostly well-formed transactions with random content, under several register
   // settings, mixed with lone random commands.
   task automatic test_random_traffic();
      int stop_at;
      for (int k = 0; k < 4; k++) begin
         if (k == 0) begin
            set_config(8'd1, 8'd1, 8'd1);
         end else begin
            set_config(8'($urandom_range(3, 1)), 8'($urandom_range(3, 1)),
                       8'($urandom_range(12, 1)));
         end
         stop_at = ticks_sent + 120;
         while (ticks_sent < stop_at) begin
            gap_mode   = ($urandom_range(3) != 0);
            stall_mode = ($urandom_range(3) != 0);
            if ($urandom_range(9) < 8) begin
               run_transaction();
            end else begin
               run_command(3'($urandom_range(7)), 8'($urandom), 8'($urandom),
                           pick_ack_after(), 1'b1);
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Receiver stalls, checking, run control
   // ---------------------------------------------------------------------------------

   // Stalls come in runs of random length; a requested hold-off overrides them.
   initial begin
      int r;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
            stall_run = 0;
         end else if (stall_run > 0) begin
            stall_run--;
         end else if (!stall_mode) begin
            rsp_stall = 1'b0;
         end else begin
            r = $urandom_range(99);
            if (r < 70) begin
               rsp_stall = 1'b0;
               stall_run = $urandom_range(4);
            end else if (r < 95) begin
               rsp_stall = 1'b1;
               stall_run = $urandom_range(2);
            end else begin
               rsp_stall = 1'b1;
               stall_run = $urandom_range(30, 8);
            end
         end
      end
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("[%0t] result mismatch on %s: got 0x%0h, expected 0x%0h",
                  $realtime, what, got, want);
      end
   endtask

   // Every result word taken from the block is checked against the oldest prediction.
   initial begin
      bus_result_type got;
      bus_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got = '{rsp_scl_level, rsp_sda_level, rsp_busy_res, rsp_done_res,
                    rsp_rx_byte, rsp_ack_failed};
            if (expected_bus.size() == 0) begin
               report_mismatch("word with no prediction", 32'(got), 0);
            end else begin
               want = expected_bus.pop_front();
               if (got.scl !== want.scl) begin
                  report_mismatch("scl_level", 32'(got.scl), 32'(want.scl));
               end
               if (got.sda !== want.sda) begin
                  report_mismatch("sda_level", 32'(got.sda), 32'(want.sda));
               end
               if (got.busy !== want.busy) begin
                  report_mismatch("busy_res", 32'(got.busy), 32'(want.busy));
               end
               if (got.done !== want.done) begin
                  report_mismatch("done_res", 32'(got.done), 32'(want.done));
               end
               if (got.rx !== want.rx) begin
                  report_mismatch("rx_byte", 32'(got.rx), 32'(want.rx));
               end
               if (got.failed !== want.failed) begin
                  report_mismatch("ack_failed", 32'(got.failed), 32'(want.failed));
               end
            end
         end
      end
   end

   // Ends a hung run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("i2c_master_bit_sequencer test failed");
      $finish;
   end

   initial begin
      predictor_reset();
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_directed_commands();
      test_long_poll();
      test_back_pressure();
      test_random_traffic();

      // Let every outstanding word come out, then give the pipeline time to show
      // any word that should not be there.
      @(negedge clock);
      req_valid  = 1'b0;
      stall_mode = 1'b0;
      while (expected_bus.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("i2c_master_bit_sequencer test passed");
      end else begin
         $display("i2c_master_bit_sequencer test failed");
      end
      $finish;
   end

endmodule
